### rtl/pld_pkg.sv
// ---------------------------------------------------------------------------
// pld_pkg: shared types and constants for the PID line-follow drive
// Stage payload structs, field widths and the constant-divisor multipliers.
// ---------------------------------------------------------------------------
`default_nettype none

package pld_pkg;

    localparam int ERR_W   = 13;
    localparam int DERIV_W = 14;
    localparam int SUM_W   = 32;
    localparam int DUTY_W  = 8;
    localparam int STEER_W = 9;
    localparam int PD_W    = 21;

    // error / 20: multiply magnitude by ceil(2^16 / 20), keep the bits above 2^16
    localparam int          DIV20_SHIFT = 16;
    localparam logic [11:0] DIV20_MAGIC = 12'd3277;
    localparam int          PQ_W        = 9;

    // sum / 10000: multiply magnitude by ceil(2^45 / 10000), keep the bits above 2^45
    localparam int          DIV10K_SHIFT = 45;
    localparam logic [31:0] DIV10K_MAGIC = 32'hD1B7_1759;
    localparam int          IQ_W         = 19;

    localparam int DTERM_W = 18;

    // output of the integrator stage
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DERIV_W-1:0] deriv;
        logic signed [SUM_W-1:0]   sum;
    } integ_t;

    // output of the scaling stage: the three controller terms
    typedef struct packed {
        logic signed [PQ_W-1:0]    p_term;
        logic [IQ_W-1:0]           i_mag;
        logic                      i_neg;
        logic signed [DTERM_W-1:0] d_term;
    } terms_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic signed [STEER_W-1:0] steer;
        logic                      right_rev_pin;
        logic                      right_fwd_pin;
        logic                      left_rev_pin;
        logic                      left_fwd_pin;
        logic [DUTY_W-1:0]         right_duty;
        logic [DUTY_W-1:0]         left_duty;
    } drive_t;

    localparam int DRIVE_W = $bits(drive_t);

endpackage

`default_nettype wire

### rtl/pld_integ.sv
// ---------------------------------------------------------------------------
// pld_integ: input stage with error history and saturating integral
// Registers each sample, its difference to the previous sample and the
// running error sum clamped to the 32-bit signed range.
// ---------------------------------------------------------------------------
`default_nettype none

module pld_integ (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [pld_pkg::ERR_W-1:0]   in_err,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output pld_pkg::integ_t                         out_data
);

    logic                                  valid_reg;
    logic                                  valid_next;
    logic signed [pld_pkg::ERR_W-1:0]      prev_error_reg;
    logic signed [pld_pkg::SUM_W-1:0]      error_sum_reg;
    logic signed [pld_pkg::SUM_W-1:0]      error_sum_next;
    logic signed [pld_pkg::DERIV_W-1:0]    deriv_reg;
    logic signed [pld_pkg::DERIV_W-1:0]    deriv_next;
    logic signed [pld_pkg::SUM_W:0]        sum_wide;
    logic                                  accept;

    // take a transfer when the stage is empty or drains this cycle
    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // saturating integral and first difference
    always_comb begin
        sum_wide = {error_sum_reg[pld_pkg::SUM_W-1], error_sum_reg}
                 + {{(pld_pkg::SUM_W+1-pld_pkg::ERR_W){in_err[pld_pkg::ERR_W-1]}}, in_err};
        if (sum_wide[pld_pkg::SUM_W] != sum_wide[pld_pkg::SUM_W-1]) begin
            error_sum_next = sum_wide[pld_pkg::SUM_W]
                           ? {1'b1, {(pld_pkg::SUM_W-1){1'b0}}}
                           : {1'b0, {(pld_pkg::SUM_W-1){1'b1}}};
        end else begin
            error_sum_next = sum_wide[pld_pkg::SUM_W-1:0];
        end
        deriv_next = {in_err[pld_pkg::ERR_W-1], in_err}
                   - {prev_error_reg[pld_pkg::ERR_W-1], prev_error_reg};
    end

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // controller state doubles as the stage payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            prev_error_reg <= '0;
            error_sum_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                prev_error_reg <= in_err;
                error_sum_reg  <= error_sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            deriv_reg <= deriv_next;
        end
    end

    assign out_valid      = valid_reg;
    assign out_data.err   = prev_error_reg;
    assign out_data.deriv = deriv_reg;
    assign out_data.sum   = error_sum_reg;

endmodule

`default_nettype wire

### rtl/pld_scale.sv
// ---------------------------------------------------------------------------
// pld_scale: gain stage
// Forms error/20 and |sum|/10000 by reciprocal multiplication (truncating
// toward zero) and 10 * difference, then registers the three terms.
// ---------------------------------------------------------------------------
`default_nettype none

module pld_scale (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pld_pkg::integ_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output pld_pkg::terms_t       out_data
);

    localparam int PPROD_W = pld_pkg::ERR_W + 12;
    localparam int IPROD_W = 2 * pld_pkg::SUM_W;

    logic                                valid_reg;
    logic                                valid_next;
    pld_pkg::terms_t                     terms_reg;
    pld_pkg::terms_t                     terms_next;
    logic                                accept;
    logic                                e_neg;
    logic [pld_pkg::ERR_W-1:0]           e_mag;
    logic [PPROD_W-1:0]                  p_prod;
    logic [pld_pkg::PQ_W-1:0]            p_quot;
    logic [pld_pkg::SUM_W-1:0]           s_mag;
    logic [IPROD_W-1:0]                  i_prod;
    logic signed [pld_pkg::DTERM_W-1:0]  d_ext;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // form the three controller terms
    always_comb begin
        // proportional term: signed quotient by 20
        e_neg  = in_data.err[pld_pkg::ERR_W-1];
        e_mag  = e_neg ? (~in_data.err + 1'b1) : in_data.err;
        p_prod = PPROD_W'(e_mag) * PPROD_W'(pld_pkg::DIV20_MAGIC);
        p_quot = p_prod[pld_pkg::DIV20_SHIFT +: pld_pkg::PQ_W];
        terms_next.p_term = e_neg ? (~p_quot + 1'b1) : p_quot;

        // integral term: magnitude quotient by 10000, sign applied downstream
        s_mag  = in_data.sum[pld_pkg::SUM_W-1] ? (~in_data.sum + 1'b1) : in_data.sum;
        i_prod = IPROD_W'(s_mag) * IPROD_W'(pld_pkg::DIV10K_MAGIC);
        terms_next.i_mag = i_prod[pld_pkg::DIV10K_SHIFT +: pld_pkg::IQ_W];
        terms_next.i_neg = in_data.sum[pld_pkg::SUM_W-1];

        // derivative term: 8x + 2x
        d_ext = {{(pld_pkg::DTERM_W-pld_pkg::DERIV_W){in_data.deriv[pld_pkg::DERIV_W-1]}},
                 in_data.deriv};
        terms_next.d_term = (d_ext <<< 3) + (d_ext <<< 1);
    end

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            terms_reg <= terms_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = terms_reg;

endmodule

`default_nettype wire

### rtl/pld_mix.sv
// ---------------------------------------------------------------------------
// pld_mix: steering sum, clamp and wheel drive
// Adds the three terms, clamps to plus or minus max speed, slows one wheel
// and registers duties and direction pins as the result.
// ---------------------------------------------------------------------------
`default_nettype none

module pld_mix (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [pld_pkg::DUTY_W-1:0]   max_speed,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire pld_pkg::terms_t              in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output pld_pkg::drive_t                   out_data
);

    localparam int SPD_W = pld_pkg::DUTY_W + 2;

    logic                                valid_reg;
    logic                                valid_next;
    pld_pkg::drive_t                     drive_reg;
    pld_pkg::drive_t                     drive_next;
    logic                                accept;
    logic signed [pld_pkg::PD_W-1:0]     p_ext;
    logic signed [pld_pkg::PD_W-1:0]     i_ext;
    logic signed [pld_pkg::PD_W-1:0]     d_ext;
    logic signed [pld_pkg::PD_W-1:0]     pd_sum;
    logic signed [pld_pkg::PD_W-1:0]     lim;
    logic signed [pld_pkg::STEER_W-1:0]  steer;
    logic signed [SPD_W-1:0]             lim_s;
    logic signed [SPD_W-1:0]             steer_s;
    logic signed [SPD_W-1:0]             lspeed;
    logic signed [SPD_W-1:0]             rspeed;
    logic [SPD_W-1:0]                    lmag;
    logic [SPD_W-1:0]                    rmag;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // sum the terms and clamp to the speed limit
    always_comb begin
        p_ext = {{(pld_pkg::PD_W-pld_pkg::PQ_W){in_data.p_term[pld_pkg::PQ_W-1]}},
                 in_data.p_term};
        i_ext = {{(pld_pkg::PD_W-pld_pkg::IQ_W){1'b0}}, in_data.i_mag};
        if (in_data.i_neg) begin
            i_ext = -i_ext;
        end
        d_ext = {{(pld_pkg::PD_W-pld_pkg::DTERM_W){in_data.d_term[pld_pkg::DTERM_W-1]}},
                 in_data.d_term};
        pd_sum = p_ext + i_ext + d_ext;
        lim    = {{(pld_pkg::PD_W-pld_pkg::DUTY_W){1'b0}}, max_speed};
        priority if (pd_sum > lim) begin
            steer = lim[pld_pkg::STEER_W-1:0];
        end else if (pd_sum < -lim) begin
            steer = pld_pkg::STEER_W'(-lim);
        end else begin
            steer = pd_sum[pld_pkg::STEER_W-1:0];
        end
    end

    // slow the wheel on the side of the correction
    always_comb begin
        lim_s   = {{(SPD_W-pld_pkg::DUTY_W){1'b0}}, max_speed};
        steer_s = {{(SPD_W-pld_pkg::STEER_W){steer[pld_pkg::STEER_W-1]}}, steer};
        if (steer[pld_pkg::STEER_W-1]) begin
            lspeed = lim_s + steer_s;
            rspeed = lim_s;
        end else begin
            lspeed = lim_s;
            rspeed = lim_s - steer_s;
        end
        lmag = lspeed[SPD_W-1] ? (~lspeed + 1'b1) : lspeed;
        rmag = rspeed[SPD_W-1] ? (~rspeed + 1'b1) : rspeed;

        drive_next.steer         = steer;
        drive_next.left_duty     = lmag[pld_pkg::DUTY_W-1:0];
        drive_next.right_duty    = rmag[pld_pkg::DUTY_W-1:0];
        drive_next.left_fwd_pin  = !lspeed[SPD_W-1];
        drive_next.left_rev_pin  = lspeed[SPD_W-1];
        // right motor is wired inverted
        drive_next.right_fwd_pin = rspeed[SPD_W-1];
        drive_next.right_rev_pin = !rspeed[SPD_W-1];
    end

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = drive_reg;

endmodule

`default_nettype wire

### rtl/pid_line_follow_drive.sv
// Path: an input transfer is registered in the integrator, gain and drive stages in turn before m_tvalid.
// Throughput: 1 sample per cycle while m_tready is high; three registered stages (integrator,
// gain multipliers, clamp and drive), each with its own valid and ready.
// Reset: aresetn low clears stage valids, previous error and integral,
// and sets max_speed to 255.
// ---------------------------------------------------------------------------
// pid_line_follow_drive: PID steering for a two-wheel line follower
// Turns line-position error samples into wheel PWM duties and pin levels.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_line_follow_drive (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration: max_speed
    input  wire logic         cfg_wr_en,
    input  wire logic [7:0]   cfg_wr_data,
    // input samples
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // [12:0] line_error
    // drive results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [7:0] left_duty, [15:8] right_duty, [16] left_fwd_pin, [17] left_rev_pin,
    // [18] right_fwd_pin, [19] right_rev_pin, [28:20] steer
    output logic [31:0]       m_tdata
);

    logic [pld_pkg::DUTY_W-1:0] max_speed_reg;
    logic                       integ_valid;
    logic                       integ_ready;
    pld_pkg::integ_t            integ_data;
    logic                       terms_valid;
    logic                       terms_ready;
    pld_pkg::terms_t            terms_data;
    pld_pkg::drive_t            drive_data;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= 8'd255;
        end else if (cfg_wr_en) begin
            max_speed_reg <= cfg_wr_data;
        end
    end

    pld_integ u_integ (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_err    (s_tdata[pld_pkg::ERR_W-1:0]),
        .out_valid (integ_valid),
        .out_ready (integ_ready),
        .out_data  (integ_data)
    );

    pld_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (integ_valid),
        .in_ready  (integ_ready),
        .in_data   (integ_data),
        .out_valid (terms_valid),
        .out_ready (terms_ready),
        .out_data  (terms_data)
    );

    pld_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .max_speed (max_speed_reg),
        .in_valid  (terms_valid),
        .in_ready  (terms_ready),
        .in_data   (terms_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (drive_data)
    );

    assign m_tdata = {(32 - pld_pkg::DRIVE_W)'(0), drive_data};

endmodule

`default_nettype wire

### rtl/pld_checker.sv
// ---------------------------------------------------------------------------
// pld_checker: port-level checks for the PID line-follow drive
// Watches results against a shadow of max_speed and the handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module pld_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         cfg_wr_en,
    input wire logic [7:0]   cfg_wr_data,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [15:0]  s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [31:0]  m_tdata
);

    logic [7:0] max_speed_reg;

    // shadow the speed limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= 8'd255;
        end else if (cfg_wr_en) begin
            max_speed_reg <= cfg_wr_data;
        end
    end

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // wheel speeds never go negative: left forward, right reverse
    a_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16] && !m_tdata[17] && !m_tdata[18] && m_tdata[19]))
        else $error("unexpected direction pins");

    // the wheel opposite the correction runs at max_speed duty, the other at max + or - steer
    a_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[28]
            ? (m_tdata[15:8] == max_speed_reg
               && {1'b0, m_tdata[7:0]} == ({1'b0, max_speed_reg} + m_tdata[28:20]))
            : (m_tdata[7:0] == max_speed_reg
               && {1'b0, m_tdata[15:8]} == ({1'b0, max_speed_reg} - m_tdata[28:20]))))
        else $error("duties disagree with steer");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind pid_line_follow_drive pld_checker u_pld_checker (.*);

`default_nettype wire

### verif/pld_drive_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pld_drive_checker: result checker for the PID line-follow drive
// Watches the configuration port and both stream channels, predicts each
// drive result from its own copy of the controller state, and compares
// every result transfer field by field against the oldest prediction.
// ---------------------------------------------------------------------------

module pld_drive_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    output int               fail_count,
    output int               pending
);

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam longint P_DIV   = 20;
    localparam longint I_DIV   = 10000;
    localparam longint D_GAIN  = 10;

    // controller state as seen from outside
    logic [7:0]                       max_speed = 8'd255;
    logic signed [pld_pkg::ERR_W-1:0] prev_err  = '0;
    logic signed [pld_pkg::SUM_W-1:0] err_sum   = '0;

    pld_pkg::drive_t drive_expected[$];

    // advance the controller by one sample and return the drive it produces
    function automatic pld_pkg::drive_t compute_drive(
        input logic signed [pld_pkg::ERR_W-1:0] err);
        longint e, deriv, sum_next, steer_v, lim, lspeed, rspeed;
        pld_pkg::drive_t d;
        e        = err;
        deriv    = e - longint'(prev_err);
        sum_next = longint'(err_sum) + e;
        if (sum_next > SUM_MAX) sum_next = SUM_MAX;
        if (sum_next < SUM_MIN) sum_next = SUM_MIN;
        err_sum  = sum_next[pld_pkg::SUM_W-1:0];
        prev_err = err;

        // truncating division on signed operands
        steer_v = e / P_DIV + sum_next / I_DIV + deriv * D_GAIN;
        lim     = longint'(max_speed);
        if (steer_v > lim)  steer_v = lim;
        if (steer_v < -lim) steer_v = -lim;

        // negative steer slows the left wheel, otherwise the right one
        if (steer_v < 0) begin
            lspeed = lim + steer_v;
            rspeed = lim;
        end else begin
            lspeed = lim;
            rspeed = lim - steer_v;
        end

        d.left_duty     = (lspeed < 0) ? pld_pkg::DUTY_W'(-lspeed)
                                       : pld_pkg::DUTY_W'(lspeed);
        d.right_duty    = (rspeed < 0) ? pld_pkg::DUTY_W'(-rspeed)
                                       : pld_pkg::DUTY_W'(rspeed);
        d.left_fwd_pin  = (lspeed >= 0);
        d.left_rev_pin  = (lspeed < 0);
        // right wheel pins are wired the other way round
        d.right_fwd_pin = (rspeed < 0);
        d.right_rev_pin = (rspeed >= 0);
        d.steer         = steer_v[pld_pkg::STEER_W-1:0];
        return d;
    endfunction

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
            fail_count++;
        end
    endtask

    // sample both channels at the rising edge, like the block's own flops
    always @(posedge aclk) begin
        pld_pkg::drive_t got;
        pld_pkg::drive_t want;
        if (!aresetn) begin
            max_speed = 8'd255;
            prev_err  = '0;
            err_sum   = '0;
            drive_expected.delete();
        end else begin
            // compare a result transfer against the oldest prediction
            if (m_tvalid && m_tready) begin
                got = pld_pkg::drive_t'(m_tdata[pld_pkg::DRIVE_W-1:0]);
                if (drive_expected.size() == 0) begin
                    $error("drive result with no sample waiting: steer %0d",
                           $signed(got.steer));
                    fail_count++;
                end else begin
                    want = drive_expected.pop_front();
                    check_field("left_duty", want.left_duty, got.left_duty);
                    check_field("right_duty", want.right_duty, got.right_duty);
                    check_field("left_fwd_pin", want.left_fwd_pin, got.left_fwd_pin);
                    check_field("left_rev_pin", want.left_rev_pin, got.left_rev_pin);
                    check_field("right_fwd_pin", want.right_fwd_pin, got.right_fwd_pin);
                    check_field("right_rev_pin", want.right_rev_pin, got.right_rev_pin);
                    check_field("steer", $signed(want.steer), $signed(got.steer));
                end
            end
            // predict on every accepted sample
            if (s_tvalid && s_tready)
                drive_expected.push_back(compute_drive(s_tdata[pld_pkg::ERR_W-1:0]));
            if (cfg_wr_en)
                max_speed = cfg_wr_data;
        end
        pending = drive_expected.size();
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the PID line-follow drive
// Drives line-error samples and max_speed writes, idles both stream sides,
// and runs the integral hard against the negative rail; the checker does
// the comparing.
// ---------------------------------------------------------------------------

module tb_top;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int LATENCY       = 3;
    localparam int SEG_ITEMS     = 270;
    localparam int NUM_SEGS      = 6;
    localparam int RX_HOLD       = 300;
    localparam int RAIL_ITEMS    = 40;
    localparam int TIMEOUT_NS    = 1_000_000;
    localparam int ERR_MAX       = 4095;
    localparam int ERR_MIN       = -4096;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [12:0] line_error
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [7:0] left_duty, [15:8] right_duty, [16] left_fwd_pin,
                             // [17] left_rev_pin, [18] right_fwd_pin,
                             // [19] right_rev_pin, [28:20] steer
    int fail_count;
    int pending;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;
    int track_pos   = 0;

    pid_line_follow_drive uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    pld_drive_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always #CLK_HALF aclk = ~aclk;

    // hard stop in case a transfer never completes
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // result side: random backpressure, plus one long hold on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = RX_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // idle cycles before the next sample, drawn per cycle
    function automatic int tx_gap();
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        return gap;
    endfunction

    // line tracking: mostly a slow drift, with jumps, rails and re-centering
    function automatic logic signed [pld_pkg::ERR_W-1:0] next_line_error();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            track_pos += $urandom_range(0, 48) - 24;
            if (track_pos > ERR_MAX) track_pos = ERR_MAX;
            if (track_pos < ERR_MIN) track_pos = ERR_MIN;
        end else if (pick < 90) begin
            track_pos = $urandom_range(0, 8191) + ERR_MIN;
        end else if (pick < 93) begin
            track_pos = ERR_MAX;
        end else if (pick < 96) begin
            track_pos = ERR_MIN;
        end else begin
            track_pos = 0;
        end
        return pld_pkg::ERR_W'(track_pos);
    endfunction

    // offer one sample after a gap and hold it until the transfer
    task automatic send_error(input logic signed [pld_pkg::ERR_W-1:0] err, input int gap);
        repeat (gap) @(negedge aclk) s_tvalid <= 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(16 - pld_pkg::ERR_W){1'b0}}, err};
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid, wait out every expected result, then the pipeline depth
    task automatic wait_drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 1) @(negedge aclk);
    endtask

    task automatic write_max_speed(input logic [7:0] speed);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= speed;
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    task automatic send_list(input int errs[]);
        foreach (errs[i])
            send_error(pld_pkg::ERR_W'(errs[i]), 0);
    endtask

    initial begin : stimulus
        int seg_speed[NUM_SEGS];
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'd0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: rails, full-swing derivatives, divider boundaries
        wait_drain();
        write_max_speed(8'd255);
        send_list('{0, 4095, -4096, -4096, 4095, 0, 20, 21, -20, -21, 1, -1, 0});
        // zero max_speed clamps steering to nothing
        wait_drain();
        write_max_speed(8'd0);
        send_list('{5, -5, 4095, -4096});
        wait_drain();
        write_max_speed(8'd1);
        send_list('{1, 0, -1});

        // random segments, each with its own max_speed and idle pattern
        seg_speed = '{255, 0, $urandom_range(2, 254), 1, $urandom_range(2, 254), 255};
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            wait_drain();
            write_max_speed(8'(seg_speed[seg]));
            case (seg / 2)
                0: begin
                    tx_idle_pct = 26;
                    rx_idle_pct = 59;
                end
                1: begin
                    tx_idle_pct = 59;
                    rx_idle_pct = 26;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // long receiver hold so the pipeline fills and stalls its input
            if (seg == 4) begin
                @(posedge aclk);
                hold_req = 1'b1;
            end
            repeat (SEG_ITEMS)
                send_error(next_line_error(), tx_gap());
        end

        // hold the left rail at full rate to drive the integral hard negative
        wait_drain();
        write_max_speed(8'd255);
        repeat (RAIL_ITEMS)
            send_error(pld_pkg::ERR_W'(ERR_MIN), 0);
        send_list('{4095, 4095, 0, -4096});
        repeat (20)
            send_error(next_line_error(), 0);

        wait_drain();
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
